@@ rtl/msc_pkg.sv @@
// Shared types and constants for the majority subarray counter.
// Holds the input, result and classified-operation structs; no dependencies.
`default_nettype none

package msc_pkg;

	localparam int ELEM_W          = 32;
	localparam int TOTAL_W         = 24;
	localparam int MAX_LEN_DEFAULT = 4096;
	localparam int QUEUE_DEPTH     = 2;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element_value;
		logic                     first_of_array;
	} in_item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] running_total;
		logic               too_long;
	} out_item_t;

	// One element after classification against the target value.
	typedef struct packed {
		logic is_match;
		logic first;
	} op_t;

endpackage

`default_nettype wire

@@ rtl/majority_subarray_counter.sv @@
// Majority subarray counter: one result per element; the back end moves each element from idle to execute.
// An accepted element passes through the queue, the back-end read registers and the result register.
// The back end takes a new element only after the read then write of the count memory for the last one.
// Reset clears all control state and the target; the count memory needs no clearing pass,
// since only slots inside the prefix range visited by the current array are ever trusted.
// Depends on msc_pkg, msc_front, msc_queue and msc_back.
`default_nettype none

module majority_subarray_counter #(
	parameter int MAX_LEN = msc_pkg::MAX_LEN_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire msc_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output msc_pkg::out_item_t      out_item
);
	import msc_pkg::*;

	logic q_push;
	op_t  q_push_op;
	logic q_full;
	logic q_pop;
	op_t  q_pop_op;
	logic q_empty;

	msc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_push   (q_push),
		.q_op     (q_push_op),
		.q_full   (q_full)
	);

	msc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_push_op),
		.full    (q_full),
		.pop     (q_pop),
		.pop_op  (q_pop_op),
		.empty   (q_empty)
	);

	msc_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_op      (q_pop_op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

@@ rtl/msc_front.sv @@
// Front end: holds the target register, accepts elements and classifies them.
// Depends on msc_pkg; pushes classified operations into msc_queue.
`default_nettype none

module msc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire msc_pkg::in_item_t in_item,
	output logic                   q_push,
	output msc_pkg::op_t           q_op,
	input  wire logic              q_full
);
	import msc_pkg::*;

	logic signed [ELEM_W-1:0] target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_data;
		end
	end

	assign in_stall      = q_full;
	assign q_push        = in_valid && !q_full;
	assign q_op.is_match = (in_item.element_value == target_q);
	assign q_op.first    = in_item.first_of_array;

endmodule

`default_nettype wire

@@ rtl/msc_queue.sv @@
// Short queue of classified operations between the front and back ends.
// Depends on msc_pkg for the operation type.
`default_nettype none

module msc_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire msc_pkg::op_t push_op,
	output logic              full,
	input  wire logic         pop,
	output msc_pkg::op_t      pop_op,
	output logic              empty
);
	import msc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_op  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/msc_back.sv @@
// Back end: prefix-count memory, read-modify-write sequencer and result register.
// Depends on msc_pkg; pops classified operations from msc_queue.
`default_nettype none

module msc_back #(
	parameter int MAX_LEN = msc_pkg::MAX_LEN_DEFAULT
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	output logic                q_pop,
	input  wire msc_pkg::op_t   q_op,
	output logic                out_valid,
	input  wire logic           out_stall,
	output msc_pkg::out_item_t  out_item
);
	import msc_pkg::*;

	localparam int DEPTH  = 2 * MAX_LEN + 1;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(MAX_LEN + 2);
	localparam int SEEN_W = $clog2(MAX_LEN + 1);
	localparam logic [SLOT_W-1:0] ZERO_SLOT = SLOT_W'(MAX_LEN);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Memory entries hold occurrence counts without the initial prefix zero.
	logic [CNT_W-1:0]   mem [DEPTH];
	logic [CNT_W-1:0]   rd_a_q;
	logic [CNT_W-1:0]   rd_b_q;
	logic [SLOT_W-1:0]  addr_a_q;
	logic [SLOT_W-1:0]  addr_b_q;
	op_t                op_q;

	state_t             state_q;
	logic [SLOT_W-1:0]  prefix_q;
	logic [SLOT_W-1:0]  lo_q;
	logic [SLOT_W-1:0]  hi_q;
	logic               zero_wr_q;
	logic [SEEN_W-1:0]  seen_q;
	logic [CNT_W-1:0]   below_q;
	logic [TOTAL_W-1:0] total_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic [SLOT_W-1:0]  eff_prefix;
	logic [SLOT_W-1:0]  addr_a;
	logic [SLOT_W-1:0]  addr_b;
	logic               valid_a;
	logic               valid_b;
	logic [CNT_W-1:0]   cnt_a;
	logic [CNT_W-1:0]   below_nxt;
	logic [TOTAL_W-1:0] total_nxt;
	logic [CNT_W-1:0]   wr_data;
	logic               too_long;
	logic               finish;
	logic               wr_en;

	// A start mark resets the prefix before the addresses are formed.
	always_comb begin
		eff_prefix = q_op.first ? ZERO_SLOT : prefix_q;
		addr_a     = q_op.is_match ? eff_prefix : eff_prefix - 1'b1;
		addr_b     = q_op.is_match ? eff_prefix + 1'b1 : eff_prefix - 1'b1;
	end

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	// The prefix walks in unit steps, so the slots touched in this array form the
	// range lo..hi. Every slot in it was written, except the zero slot, which may
	// only have been the starting point.
	always_comb begin
		valid_a   = (addr_a_q >= lo_q) && (addr_a_q <= hi_q)
			&& ((addr_a_q != ZERO_SLOT) || zero_wr_q);
		valid_b   = (addr_b_q >= lo_q) && (addr_b_q <= hi_q)
			&& ((addr_b_q != ZERO_SLOT) || zero_wr_q);
		cnt_a     = (valid_a ? rd_a_q : '0) + CNT_W'(addr_a_q == ZERO_SLOT);
		below_nxt = op_q.is_match ? below_q + cnt_a : below_q - cnt_a;
		total_nxt = total_q + TOTAL_W'(below_nxt);
		wr_data   = (valid_b ? rd_b_q : '0) + CNT_W'(1);
		too_long  = (seen_q == SEEN_W'(MAX_LEN));
		finish    = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
		wr_en     = finish && !too_long;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_a_q   <= mem[addr_a];
			rd_b_q   <= mem[addr_b];
			addr_a_q <= addr_a;
			addr_b_q <= addr_b;
			op_q     <= q_op;
		end
		if (wr_en) begin
			mem[addr_b_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prefix_q    <= ZERO_SLOT;
			lo_q        <= ZERO_SLOT;
			hi_q        <= ZERO_SLOT;
			zero_wr_q   <= 1'b0;
			seen_q      <= '0;
			below_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && !finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_EXEC;
						if (q_op.first) begin
							prefix_q  <= ZERO_SLOT;
							lo_q      <= ZERO_SLOT;
							hi_q      <= ZERO_SLOT;
							zero_wr_q <= 1'b0;
							seen_q    <= '0;
							below_q   <= '0;
							total_q   <= '0;
						end
					end
				end
				ST_EXEC: begin
					if (finish) begin
						state_q                  <= ST_IDLE;
						out_valid_q              <= 1'b1;
						out_item_q.too_long      <= too_long;
						out_item_q.running_total <= too_long ? total_q : total_nxt;
						if (!too_long) begin
							prefix_q <= addr_b_q;
							below_q  <= below_nxt;
							total_q  <= total_nxt;
							seen_q   <= seen_q + 1'b1;
							if (addr_b_q < lo_q) begin
								lo_q <= addr_b_q;
							end
							if (addr_b_q > hi_q) begin
								hi_q <= addr_b_q;
							end
							if (addr_b_q == ZERO_SLOT) begin
								zero_wr_q <= 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire
